/* design/tbog_pkg.sv */
// shared types, constants and helpers of the tdoa bucket outlier gate
`default_nettype none

package tbog_pkg;

   // field widths
   localparam int unsigned POS_W       = 24;
   localparam int unsigned JAC_W       = 20;
   localparam int unsigned LEVEL_W     = 24;
   localparam int unsigned FILL_W      = 4;
   localparam int unsigned HOLD_W      = 8;
   localparam int unsigned OUT_LEVEL_W = 3;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned LVL_CNT_W   = 3;

   // datapath widths
   localparam int unsigned OPND_W  = 25;
   localparam int unsigned MUL_W   = 2 * OPND_W;
   localparam int unsigned SEP2_W  = 50;
   localparam int unsigned SQ_W    = 47;
   localparam int unsigned J2_W    = 40;
   localparam int unsigned LVL2_W  = 48;
   localparam int unsigned ACC_W   = 88;
   localparam int unsigned SPLIT_A = 24;
   localparam int unsigned SPLIT_B = 20;
   localparam int unsigned R2_SHIFT = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_LAST   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEPT_COUNT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FILL     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSE_DELAY  = 3'd7;

   localparam logic [FILL_W-1:0] ACCEPT_COUNT_RESET = 4'd3;
   localparam logic [FILL_W-1:0] MAX_FILL_RESET     = 4'd10;
   localparam logic [HOLD_W-1:0] CLOSE_DELAY_RESET  = 8'd30;

   function automatic logic [LEVEL_W-1:0] level_reset(input logic [LVL_CNT_W-1:0] idx);
      logic [LEVEL_W-1:0] val;
      case (idx)
         3'd0:    val = 24'd26214;
         3'd1:    val = 24'd52429;
         3'd2:    val = 24'd78643;
         3'd3:    val = 24'd104858;
         default: val = 24'd131072;
      endcase
      return val;
   endfunction

   typedef enum logic [3:0] {
      OP_NOP,
      OP_SEP_X,
      OP_SEP_Y,
      OP_SEP_Z,
      OP_DD,
      OP_RES,
      OP_JAC_X,
      OP_JAC_Y,
      OP_JAC_Z,
      OP_LVL_SQ,
      OP_P00,
      OP_P01,
      OP_P10,
      OP_P11,
      OP_CMP
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_GEO,
      ST_LEVEL,
      ST_LDRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      op_type                op;
      logic [LVL_CNT_W-1:0]  lvl;
      logic                  load;
      logic                  commit;
      logic                  req_ready;
      logic                  rsp_valid;
   } cmd_type;

   typedef struct packed {
      logic geo_ok;
   } status_type;

endpackage

`default_nettype wire

/* design/tbog_if.sv */
// request and response channel interfaces
`default_nettype none

interface tbog_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [tbog_pkg::POS_W-1:0]   anchor_a_x;
   logic signed [tbog_pkg::POS_W-1:0]   anchor_a_y;
   logic signed [tbog_pkg::POS_W-1:0]   anchor_a_z;
   logic signed [tbog_pkg::POS_W-1:0]   anchor_b_x;
   logic signed [tbog_pkg::POS_W-1:0]   anchor_b_y;
   logic signed [tbog_pkg::POS_W-1:0]   anchor_b_z;
   logic signed [tbog_pkg::POS_W-1:0]   distance_diff;
   logic signed [tbog_pkg::POS_W-1:0]   residual;
   logic signed [tbog_pkg::JAC_W-1:0]   jac_x;
   logic signed [tbog_pkg::JAC_W-1:0]   jac_y;
   logic signed [tbog_pkg::JAC_W-1:0]   jac_z;

   modport source (
      output valid, anchor_a_x, anchor_a_y, anchor_a_z, anchor_b_x, anchor_b_y,
             anchor_b_z, distance_diff, residual, jac_x, jac_y, jac_z,
      input  ready
   );
   modport sink (
      input  valid, anchor_a_x, anchor_a_y, anchor_a_z, anchor_b_x, anchor_b_y,
             anchor_b_z, distance_diff, residual, jac_x, jac_y, jac_z,
      output ready
   );
endinterface

interface tbog_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  sample_good;
   logic                                  geometry_ok;
   logic [tbog_pkg::OUT_LEVEL_W-1:0]      level_index;

   modport source (
      output valid, sample_good, geometry_ok, level_index,
      input  ready
   );
   modport sink (
      input  valid, sample_good, geometry_ok, level_index,
      output ready
   );
endinterface

`default_nettype wire

/* design/tdoa_bucket_outlier_gate.sv */
// TDoA bucket outlier gate: one pass/fail verdict per measurement beat.
// req_bus carries one measurement per beat (valid/ready); rsp_bus returns
// exactly one result beat per accepted measurement, in order.
// csr_wen/csr_index/csr_wdata write the level, bucket and hold-off registers;
// write them only while no measurement is in flight.
// Work runs on one shared 25x25 multiplier: eight squares for geometry,
// residual and Jacobian, then per level one level square and four partial
// products of level^2 * |jac|^2, compared against residual^2 * 2^32.
// A geometry reject skips the level passes and goes straight to the commit;
// one measurement is in the datapath at a time.
// The result sits in an output register, so a new beat is taken while the
// previous result still waits; a stalled receiver only holds the final
// commit of the next measurement until the register frees.
// Reset restores the register defaults, empties all buckets, clears the
// hold-off counter and the previous level, and drops rsp valid.
`default_nettype none

module tdoa_bucket_outlier_gate #(
   parameter int unsigned NUM_LEVELS = 5
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   tbog_req_if.sink                                 req_bus,
   tbog_rsp_if.source                               rsp_bus,
   input  wire logic                                csr_wen,
   input  wire logic [tbog_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [tbog_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   tbog_pkg::cmd_type    cmd;
   tbog_pkg::status_type status;

   tbog_ctrl #(
      .NUM_LEVELS (NUM_LEVELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tbog_dp #(
      .NUM_LEVELS (NUM_LEVELS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

`default_nettype wire

/* design/tbog_ctrl.sv */
// controller state machine: sequences the shared multiplier and the commit
`default_nettype none

module tbog_ctrl #(
   parameter int unsigned NUM_LEVELS = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 rsp_ready,
   input  wire tbog_pkg::status_type status,
   output tbog_pkg::cmd_type         cmd
);

   localparam logic [2:0] PRE_LAST   = 3'd7;
   localparam logic [2:0] LEVEL_LAST = 3'd6;
   localparam logic [tbog_pkg::LVL_CNT_W-1:0] LVL_LAST =
      tbog_pkg::LVL_CNT_W'(NUM_LEVELS - 1);

   tbog_pkg::state_type                 state_ff, state_in;
   logic [2:0]                          step_ff, step_in;
   logic [tbog_pkg::LVL_CNT_W-1:0]      lvl_ff, lvl_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      lvl_in   = lvl_ff;
      case (state_ff)
         tbog_pkg::ST_IDLE: begin
            step_in = '0;
            lvl_in  = '0;
            if (req_valid) begin
               state_in = tbog_pkg::ST_PRE;
            end
         end
         tbog_pkg::ST_PRE: begin
            step_in = step_ff + 3'd1;
            if (step_ff == PRE_LAST) begin
               state_in = tbog_pkg::ST_GEO;
            end
         end
         tbog_pkg::ST_GEO: begin
            step_in = '0;
            lvl_in  = '0;
            state_in = status.geo_ok ? tbog_pkg::ST_LEVEL : tbog_pkg::ST_COMMIT;
         end
         tbog_pkg::ST_LEVEL: begin
            if (step_ff == LEVEL_LAST) begin
               step_in = '0;
               if (lvl_ff == LVL_LAST) begin
                  state_in = tbog_pkg::ST_LDRAIN;
               end else begin
                  lvl_in = lvl_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         tbog_pkg::ST_LDRAIN: begin
            state_in = tbog_pkg::ST_COMMIT;
         end
         tbog_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in = tbog_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tbog_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.op        = tbog_pkg::OP_NOP;
      cmd.lvl       = lvl_ff;
      cmd.rsp_valid = rsp_valid_ff;
      case (state_ff)
         tbog_pkg::ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.load      = req_valid;
         end
         tbog_pkg::ST_PRE: begin
            case (step_ff)
               3'd0:    cmd.op = tbog_pkg::OP_SEP_X;
               3'd1:    cmd.op = tbog_pkg::OP_SEP_Y;
               3'd2:    cmd.op = tbog_pkg::OP_SEP_Z;
               3'd3:    cmd.op = tbog_pkg::OP_DD;
               3'd4:    cmd.op = tbog_pkg::OP_RES;
               3'd5:    cmd.op = tbog_pkg::OP_JAC_X;
               3'd6:    cmd.op = tbog_pkg::OP_JAC_Y;
               default: cmd.op = tbog_pkg::OP_JAC_Z;
            endcase
         end
         tbog_pkg::ST_LEVEL: begin
            // bubble after the level square so the partials see it
            case (step_ff)
               3'd0:    cmd.op = tbog_pkg::OP_LVL_SQ;
               3'd2:    cmd.op = tbog_pkg::OP_P00;
               3'd3:    cmd.op = tbog_pkg::OP_P01;
               3'd4:    cmd.op = tbog_pkg::OP_P10;
               3'd5:    cmd.op = tbog_pkg::OP_P11;
               3'd6:    cmd.op = tbog_pkg::OP_CMP;
               default: cmd.op = tbog_pkg::OP_NOP;
            endcase
         end
         tbog_pkg::ST_COMMIT: begin
            cmd.commit = out_free;
         end
         default: begin
            cmd.op = tbog_pkg::OP_NOP;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbog_pkg::ST_IDLE;
         step_ff      <= '0;
         lvl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         lvl_ff       <= lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && cmd.req_ready) |=> (state_ff == tbog_pkg::ST_PRE))
      else $error("accepted beat did not start the sequence");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tbog_pkg::ST_COMMIT && out_free) |=> rsp_valid_ff)
      else $error("commit did not raise the response");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tbog_pkg::ST_LEVEL) |-> (lvl_ff <= LVL_LAST && step_ff <= LEVEL_LAST))
      else $error("level sequencer out of range");

endmodule

`default_nettype wire

/* design/tbog_dp.sv */
// datapath: operand capture, shared multiplier, accumulators, buckets and result
`default_nettype none

module tbog_dp #(
   parameter int unsigned NUM_LEVELS = 5
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire tbog_pkg::cmd_type                      cmd,
   output tbog_pkg::status_type                        status,
   tbog_req_if.sink                                    req_bus,
   tbog_rsp_if.source                                  rsp_bus,
   input  wire logic                                   csr_wen,
   input  wire logic [tbog_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [tbog_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int unsigned LVL_W = $clog2(NUM_LEVELS + 1);
   localparam int unsigned IDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam logic [LVL_W-1:0] NONE_CODE = LVL_W'(NUM_LEVELS);
   localparam int unsigned OW = tbog_pkg::OPND_W;
   localparam int unsigned SA = tbog_pkg::SPLIT_A;
   localparam int unsigned SB = tbog_pkg::SPLIT_B;

   // configuration
   logic [tbog_pkg::LEVEL_W-1:0] level_ff [NUM_LEVELS];
   logic [tbog_pkg::LEVEL_W-1:0] level_in [NUM_LEVELS];
   logic [tbog_pkg::FILL_W-1:0]  accept_ff, accept_in;
   logic [tbog_pkg::FILL_W-1:0]  max_fill_ff, max_fill_in;
   logic [tbog_pkg::HOLD_W-1:0]  close_ff, close_in;

   // operands and accumulators
   logic [OW-1:0]                opnd_ff [8];
   logic [OW-1:0]                opnd_in [8];
   logic [OW-1:0]                mul_a, mul_b;
   logic [tbog_pkg::MUL_W-1:0]   mul_ff, mul_in;
   tbog_pkg::op_type             op_d_ff;
   logic [tbog_pkg::LVL_CNT_W-1:0] lvl_d_ff;
   logic [tbog_pkg::SEP2_W-1:0]  sep2_ff, sep2_in;
   logic [tbog_pkg::SQ_W-1:0]    dd2_ff, dd2_in;
   logic [tbog_pkg::SQ_W-1:0]    r2_ff, r2_in;
   logic [tbog_pkg::J2_W-1:0]    j2_ff, j2_in;
   logic [tbog_pkg::LVL2_W-1:0]  lvl2_ff, lvl2_in;
   logic [tbog_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [tbog_pkg::ACC_W-1:0]   r2_scaled;
   logic                         below_ff [NUM_LEVELS];
   logic                         below_in [NUM_LEVELS];

   // gate state
   logic [tbog_pkg::FILL_W-1:0]  bucket_ff [NUM_LEVELS];
   logic [tbog_pkg::FILL_W-1:0]  bucket_in [NUM_LEVELS];
   logic [tbog_pkg::FILL_W-1:0]  fill_new [NUM_LEVELS];
   logic [tbog_pkg::HOLD_W-1:0]  hold_ff, hold_in;
   logic [LVL_W-1:0]             prev_ff, prev_in;
   logic [LVL_W-1:0]             sel, idx;
   logic [tbog_pkg::HOLD_W-1:0]  hold_next;
   logic                         good;

   // result register
   logic                               out_good_ff, out_good_in;
   logic                               out_geo_ff, out_geo_in;
   logic [tbog_pkg::OUT_LEVEL_W-1:0]   out_level_ff, out_level_in;

   function automatic logic [OW-1:0] abs_val(input logic [OW-1:0] v);
      return v[OW-1] ? (~v + OW'(1)) : v;
   endfunction

   assign req_bus.ready       = cmd.req_ready;
   assign rsp_bus.valid       = cmd.rsp_valid;
   assign rsp_bus.sample_good = out_good_ff;
   assign rsp_bus.geometry_ok = out_geo_ff;
   assign rsp_bus.level_index = out_level_ff;

   assign status.geo_ok = tbog_pkg::SEP2_W'(dd2_ff) < sep2_ff;

   // configuration writes
   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         level_in[i] = level_ff[i];
         if (i <= int'(tbog_pkg::CSR_LEVEL_LAST) && csr_wen &&
             csr_index == tbog_pkg::CSR_INDEX_W'(i)) begin
            level_in[i] = csr_wdata;
         end
      end
      accept_in   = accept_ff;
      max_fill_in = max_fill_ff;
      close_in    = close_ff;
      if (csr_wen) begin
         case (csr_index)
            tbog_pkg::CSR_ACCEPT_COUNT: accept_in   = csr_wdata[tbog_pkg::FILL_W-1:0];
            tbog_pkg::CSR_MAX_FILL:     max_fill_in = csr_wdata[tbog_pkg::FILL_W-1:0];
            tbog_pkg::CSR_CLOSE_DELAY:  close_in    = csr_wdata[tbog_pkg::HOLD_W-1:0];
            default:                    accept_in   = accept_ff;
         endcase
      end
   end

   // capture: absolute anchor separations and magnitudes
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         opnd_in[i] = opnd_ff[i];
      end
      if (cmd.load) begin
         opnd_in[0] = abs_val(OW'(req_bus.anchor_a_x) - OW'(req_bus.anchor_b_x));
         opnd_in[1] = abs_val(OW'(req_bus.anchor_a_y) - OW'(req_bus.anchor_b_y));
         opnd_in[2] = abs_val(OW'(req_bus.anchor_a_z) - OW'(req_bus.anchor_b_z));
         opnd_in[3] = abs_val(OW'(req_bus.distance_diff));
         opnd_in[4] = abs_val(OW'(req_bus.residual));
         opnd_in[5] = abs_val(OW'(req_bus.jac_x));
         opnd_in[6] = abs_val(OW'(req_bus.jac_y));
         opnd_in[7] = abs_val(OW'(req_bus.jac_z));
      end
   end

   // multiplier operand select
   always_comb begin
      case (cmd.op)
         tbog_pkg::OP_SEP_X: begin mul_a = opnd_ff[0]; mul_b = opnd_ff[0]; end
         tbog_pkg::OP_SEP_Y: begin mul_a = opnd_ff[1]; mul_b = opnd_ff[1]; end
         tbog_pkg::OP_SEP_Z: begin mul_a = opnd_ff[2]; mul_b = opnd_ff[2]; end
         tbog_pkg::OP_DD:    begin mul_a = opnd_ff[3]; mul_b = opnd_ff[3]; end
         tbog_pkg::OP_RES:   begin mul_a = opnd_ff[4]; mul_b = opnd_ff[4]; end
         tbog_pkg::OP_JAC_X: begin mul_a = opnd_ff[5]; mul_b = opnd_ff[5]; end
         tbog_pkg::OP_JAC_Y: begin mul_a = opnd_ff[6]; mul_b = opnd_ff[6]; end
         tbog_pkg::OP_JAC_Z: begin mul_a = opnd_ff[7]; mul_b = opnd_ff[7]; end
         tbog_pkg::OP_LVL_SQ: begin
            mul_a = OW'(level_ff[cmd.lvl[IDX_W-1:0]]);
            mul_b = mul_a;
         end
         tbog_pkg::OP_P00: begin
            mul_a = OW'(lvl2_ff[SA-1:0]);
            mul_b = OW'(j2_ff[SB-1:0]);
         end
         tbog_pkg::OP_P01: begin
            mul_a = OW'(lvl2_ff[SA-1:0]);
            mul_b = OW'(j2_ff[tbog_pkg::J2_W-1:SB]);
         end
         tbog_pkg::OP_P10: begin
            mul_a = OW'(lvl2_ff[tbog_pkg::LVL2_W-1:SA]);
            mul_b = OW'(j2_ff[SB-1:0]);
         end
         tbog_pkg::OP_P11: begin
            mul_a = OW'(lvl2_ff[tbog_pkg::LVL2_W-1:SA]);
            mul_b = OW'(j2_ff[tbog_pkg::J2_W-1:SB]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_in = mul_a * mul_b;
   end

   // accumulate stage, fed by the registered product and op of the multiplier
   assign r2_scaled = tbog_pkg::ACC_W'({r2_ff, {tbog_pkg::R2_SHIFT{1'b0}}});

   always_comb begin
      sep2_in = sep2_ff;
      dd2_in  = dd2_ff;
      r2_in   = r2_ff;
      j2_in   = j2_ff;
      lvl2_in = lvl2_ff;
      acc_in  = acc_ff;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         below_in[i] = below_ff[i];
      end
      case (op_d_ff)
         tbog_pkg::OP_SEP_X:  sep2_in = mul_ff;
         tbog_pkg::OP_SEP_Y,
         tbog_pkg::OP_SEP_Z:  sep2_in = sep2_ff + mul_ff;
         tbog_pkg::OP_DD:     dd2_in  = mul_ff[tbog_pkg::SQ_W-1:0];
         tbog_pkg::OP_RES:    r2_in   = mul_ff[tbog_pkg::SQ_W-1:0];
         tbog_pkg::OP_JAC_X:  j2_in   = mul_ff[tbog_pkg::J2_W-1:0];
         tbog_pkg::OP_JAC_Y,
         tbog_pkg::OP_JAC_Z:  j2_in   = j2_ff + mul_ff[tbog_pkg::J2_W-1:0];
         tbog_pkg::OP_LVL_SQ: lvl2_in = mul_ff[tbog_pkg::LVL2_W-1:0];
         tbog_pkg::OP_P00:    acc_in  = tbog_pkg::ACC_W'(mul_ff);
         tbog_pkg::OP_P01:    acc_in  = acc_ff + (tbog_pkg::ACC_W'(mul_ff) << SB);
         tbog_pkg::OP_P10:    acc_in  = acc_ff + (tbog_pkg::ACC_W'(mul_ff) << SA);
         tbog_pkg::OP_P11:    acc_in  = acc_ff + (tbog_pkg::ACC_W'(mul_ff) << (SA + SB));
         // err < level  <=>  r2 * 2^32 < level^2 * j2
         tbog_pkg::OP_CMP:    below_in[lvl_d_ff[IDX_W-1:0]] = r2_scaled < acc_ff;
         default:             acc_in  = acc_ff;
      endcase
   end

   // bucket update, level select and hold-off
   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (below_ff[i]) begin
            fill_new[i] = (bucket_ff[i] != '0) ? bucket_ff[i] - 1'b1 : bucket_ff[i];
         end else begin
            fill_new[i] = (bucket_ff[i] < max_fill_ff) ? bucket_ff[i] + 1'b1 : bucket_ff[i];
         end
      end
      sel = NONE_CODE;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (fill_new[i] < accept_ff) begin
            sel = LVL_W'(i);
         end
      end
      idx       = sel;
      hold_next = hold_ff;
      if (sel > prev_ff) begin
         hold_next = close_ff;
      end else if (sel < prev_ff && hold_ff != '0) begin
         hold_next = hold_ff - 1'b1;
         idx       = prev_ff;
      end
      good = (idx >= NONE_CODE) ? 1'b1 : below_ff[idx[IDX_W-1:0]];
   end

   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         bucket_in[i] = bucket_ff[i];
      end
      hold_in      = hold_ff;
      prev_in      = prev_ff;
      out_good_in  = out_good_ff;
      out_geo_in   = out_geo_ff;
      out_level_in = out_level_ff;
      if (cmd.commit) begin
         if (status.geo_ok) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
               bucket_in[i] = fill_new[i];
            end
            hold_in      = hold_next;
            prev_in      = idx;
            out_good_in  = good;
            out_geo_in   = 1'b1;
            out_level_in = tbog_pkg::OUT_LEVEL_W'(idx);
         end else begin
            out_good_in  = 1'b0;
            out_geo_in   = 1'b0;
            out_level_in = tbog_pkg::OUT_LEVEL_W'(prev_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            level_ff[i]  <= tbog_pkg::level_reset(tbog_pkg::LVL_CNT_W'(i));
            bucket_ff[i] <= '0;
         end
         accept_ff   <= tbog_pkg::ACCEPT_COUNT_RESET;
         max_fill_ff <= tbog_pkg::MAX_FILL_RESET;
         close_ff    <= tbog_pkg::CLOSE_DELAY_RESET;
         hold_ff     <= '0;
         prev_ff     <= '0;
         op_d_ff     <= tbog_pkg::OP_NOP;
      end else begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            level_ff[i]  <= level_in[i];
            bucket_ff[i] <= bucket_in[i];
         end
         accept_ff   <= accept_in;
         max_fill_ff <= max_fill_in;
         close_ff    <= close_in;
         hold_ff     <= hold_in;
         prev_ff     <= prev_in;
         op_d_ff     <= cmd.op;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         opnd_ff[i] <= opnd_in[i];
      end
      for (int i = 0; i < NUM_LEVELS; i++) begin
         below_ff[i] <= below_in[i];
      end
      lvl_d_ff     <= cmd.lvl;
      mul_ff       <= mul_in;
      sep2_ff      <= sep2_in;
      dd2_ff       <= dd2_in;
      r2_ff        <= r2_in;
      j2_ff        <= j2_in;
      lvl2_ff      <= lvl2_in;
      acc_ff       <= acc_in;
      out_good_ff  <= out_good_in;
      out_geo_ff   <= out_geo_in;
      out_level_ff <= out_level_in;
   end

   a_prev_range: assert property (@(posedge clock) disable iff (reset)
      prev_ff <= NONE_CODE)
      else $error("previous level beyond the none code");

   a_reject_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !status.geo_ok) |=> ($stable(prev_ff) && $stable(hold_ff)))
      else $error("geometry reject changed the gate state");

   a_level_reported: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (out_level_ff == tbog_pkg::OUT_LEVEL_W'(prev_ff)))
      else $error("reported level differs from the stored level");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// testbench of the tdoa bucket outlier gate
`timescale 1ns / 1ps

module tb_top;

   localparam int          GATE_LEVELS    = 5;
   localparam int unsigned CYCLE_LIMIT    = 600000;
   localparam int unsigned RX_HOLD_CYCLES = 500;

   localparam logic [GATE_LEVELS-1:0][tbog_pkg::LEVEL_W-1:0] LEVEL_AT_RESET =
      {24'd131072, 24'd104858, 24'd78643, 24'd52429, 24'd26214};

   typedef struct packed {
      logic [tbog_pkg::POS_W-1:0] anchor_a_x;
      logic [tbog_pkg::POS_W-1:0] anchor_a_y;
      logic [tbog_pkg::POS_W-1:0] anchor_a_z;
      logic [tbog_pkg::POS_W-1:0] anchor_b_x;
      logic [tbog_pkg::POS_W-1:0] anchor_b_y;
      logic [tbog_pkg::POS_W-1:0] anchor_b_z;
      logic [tbog_pkg::POS_W-1:0] distance_diff;
      logic [tbog_pkg::POS_W-1:0] residual;
      logic [tbog_pkg::JAC_W-1:0] jac_x;
      logic [tbog_pkg::JAC_W-1:0] jac_y;
      logic [tbog_pkg::JAC_W-1:0] jac_z;
   } measurement_type;

   typedef struct packed {
      logic                             sample_good;
      logic                             geometry_ok;
      logic [tbog_pkg::OUT_LEVEL_W-1:0] level_index;
   } verdict_type;

   typedef struct packed {
      logic [GATE_LEVELS-1:0][tbog_pkg::LEVEL_W-1:0] lvl;
      logic [tbog_pkg::FILL_W-1:0]                   accept_count;
      logic [tbog_pkg::FILL_W-1:0]                   max_fill;
      logic [tbog_pkg::HOLD_W-1:0]                   close_delay;
   } gate_cfg_type;

   localparam gate_cfg_type CFG_AT_RESET =
      {LEVEL_AT_RESET, tbog_pkg::ACCEPT_COUNT_RESET, tbog_pkg::MAX_FILL_RESET,
       tbog_pkg::CLOSE_DELAY_RESET};

   // predicts the gate verdict of every accepted measurement and checks result beats
   class verdict_board;
      logic [tbog_pkg::LEVEL_W-1:0] level_q [GATE_LEVELS];
      logic [tbog_pkg::FILL_W-1:0]  accept_count;
      logic [tbog_pkg::FILL_W-1:0]  max_fill;
      logic [tbog_pkg::HOLD_W-1:0]  close_delay;
      logic [tbog_pkg::FILL_W-1:0]  fill [GATE_LEVELS];
      logic [tbog_pkg::HOLD_W-1:0]  hold_left;
      int unsigned                  last_level;
      verdict_type                  verdicts_due [$];
      int unsigned                  mismatches;
      int unsigned                  checked;

      function new();
         for (int i = 0; i < GATE_LEVELS; i++) begin
            level_q[i] = LEVEL_AT_RESET[i];
            fill[i]    = '0;
         end
         accept_count = tbog_pkg::ACCEPT_COUNT_RESET;
         max_fill     = tbog_pkg::MAX_FILL_RESET;
         close_delay  = tbog_pkg::CLOSE_DELAY_RESET;
         hold_left    = '0;
         last_level   = 0;
         mismatches   = 0;
         checked      = 0;
      endfunction

      function void write_reg(logic [tbog_pkg::CSR_INDEX_W-1:0] idx,
                              logic [tbog_pkg::CSR_DATA_W-1:0] data);
         if (idx <= tbog_pkg::CSR_LEVEL_LAST)
            level_q[idx] = data[tbog_pkg::LEVEL_W-1:0];
         else if (idx == tbog_pkg::CSR_ACCEPT_COUNT)
            accept_count = data[tbog_pkg::FILL_W-1:0];
         else if (idx == tbog_pkg::CSR_MAX_FILL)
            max_fill = data[tbog_pkg::FILL_W-1:0];
         else if (idx == tbog_pkg::CSR_CLOSE_DELAY)
            close_delay = data[tbog_pkg::HOLD_W-1:0];
      endfunction

      function longint unsigned square(longint signed v);
         longint unsigned a;
         a = (v < 0) ? -v : v;
         return a * a;
      endfunction

      // err < lvl, done as r2 * 2^32 < lvl^2 * j2
      function bit below_level(longint unsigned r2, longint unsigned j2,
                               logic [tbog_pkg::LEVEL_W-1:0] lvl);
         logic [95:0] lhs;
         logic [95:0] rhs;
         logic [95:0] l2;
         lhs = {32'd0, r2} << 32;
         l2  = {72'd0, lvl};
         l2  = l2 * l2;
         rhs = l2 * {32'd0, j2};
         return lhs < rhs;
      endfunction

      function void note_measurement(measurement_type m);
         longint unsigned sep2;
         longint unsigned dd2;
         longint unsigned r2;
         longint unsigned j2;
         int unsigned     idx;
         bit              good;
         verdict_type     v;
         sep2 = square(longint'($signed(m.anchor_a_x)) - longint'($signed(m.anchor_b_x)))
              + square(longint'($signed(m.anchor_a_y)) - longint'($signed(m.anchor_b_y)))
              + square(longint'($signed(m.anchor_a_z)) - longint'($signed(m.anchor_b_z)));
         dd2  = square(longint'($signed(m.distance_diff)));
         if (!(dd2 < sep2)) begin
            // geometry reject leaves every bucket and the hold-off untouched
            v.sample_good = 1'b0;
            v.geometry_ok = 1'b0;
            v.level_index = last_level[tbog_pkg::OUT_LEVEL_W-1:0];
            verdicts_due.push_back(v);
            return;
         end
         r2 = square(longint'($signed(m.residual)));
         j2 = square(longint'($signed(m.jac_x))) + square(longint'($signed(m.jac_y)))
            + square(longint'($signed(m.jac_z)));
         idx = GATE_LEVELS;
         for (int i = GATE_LEVELS - 1; i >= 0; i--) begin
            if (below_level(r2, j2, level_q[i])) begin
               if (fill[i] > 0)
                  fill[i] = fill[i] - 1'b1;
            end else if (fill[i] < max_fill) begin
               fill[i] = fill[i] + 1'b1;
            end
            if (fill[i] < accept_count)
               idx = i;
         end
         if (idx > last_level) begin
            hold_left = close_delay;
         end else if (idx < last_level && hold_left > 0) begin
            hold_left = hold_left - 1'b1;
            idx = last_level;
         end
         last_level = idx;
         good = (idx >= GATE_LEVELS) ? 1'b1 : below_level(r2, j2, level_q[idx]);
         v.sample_good = good;
         v.geometry_ok = 1'b1;
         v.level_index = idx[tbog_pkg::OUT_LEVEL_W-1:0];
         verdicts_due.push_back(v);
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (verdicts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: good=%0d geo=%0d level=%0d",
                        got.sample_good, got.geometry_ok, got.level_index);
            return;
         end
         want = verdicts_due.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result %0d: expected good=%0d geo=%0d level=%0d",
                        checked, want.sample_good, want.geometry_ok, want.level_index);
               $display("result %0d: got      good=%0d geo=%0d level=%0d",
                        checked, got.sample_good, got.geometry_ok, got.level_index);
            end
         end
         checked++;
      endfunction

      function int unsigned pending();
         return verdicts_due.size();
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_wen;
   logic [tbog_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tbog_pkg::CSR_DATA_W-1:0]  csr_wdata;
   int unsigned                      rx_hold_requests = 0;

   verdict_board verdicts = new();

   tbog_req_if req_if ();
   tbog_rsp_if rsp_if ();

   tdoa_bucket_outlier_gate #(
      .NUM_LEVELS (GATE_LEVELS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         verdicts.note_measurement({req_if.anchor_a_x, req_if.anchor_a_y, req_if.anchor_a_z,
                                    req_if.anchor_b_x, req_if.anchor_b_y, req_if.anchor_b_z,
                                    req_if.distance_diff, req_if.residual,
                                    req_if.jac_x, req_if.jac_y, req_if.jac_z});
      if (!reset && rsp_if.valid && rsp_if.ready)
         verdicts.check_verdict({rsp_if.sample_good, rsp_if.geometry_ok, rsp_if.level_index});
   end

   function automatic int spread(input int unsigned mag);
      return int'($urandom_range(0, 2 * mag)) - int'(mag);
   endfunction

   function automatic measurement_type pack_meas(input int ax, ay, az, bx, by, bz, dd, res,
                                                 input int jx, jy, jz);
      measurement_type m;
      m.anchor_a_x    = ax[tbog_pkg::POS_W-1:0];
      m.anchor_a_y    = ay[tbog_pkg::POS_W-1:0];
      m.anchor_a_z    = az[tbog_pkg::POS_W-1:0];
      m.anchor_b_x    = bx[tbog_pkg::POS_W-1:0];
      m.anchor_b_y    = by[tbog_pkg::POS_W-1:0];
      m.anchor_b_z    = bz[tbog_pkg::POS_W-1:0];
      m.distance_diff = dd[tbog_pkg::POS_W-1:0];
      m.residual      = res[tbog_pkg::POS_W-1:0];
      m.jac_x         = jx[tbog_pkg::JAC_W-1:0];
      m.jac_y         = jy[tbog_pkg::JAC_W-1:0];
      m.jac_z         = jz[tbog_pkg::JAC_W-1:0];
      return m;
   endfunction

   // regime sets the residual scale: small, near the levels, large, anything
   function automatic measurement_type make_measurement(input int unsigned regime);
      int          ax, ay, az, bx, by, bz, s, dd, res, jx, jy, jz, mag;
      int unsigned kind;
      kind = $urandom_range(0, 99);
      ax = spread(1 << 22);
      ay = spread(1 << 22);
      az = spread(1 << 22);
      s  = $urandom_range(65536, 2097152);
      if ($urandom_range(0, 1) == 1)
         s = -s;
      bx = ax + s;
      by = spread(1 << 22);
      bz = spread(1 << 22);
      dd = spread(((s < 0) ? -s : s) - 1);
      jx = $urandom_range(40000, 65536);
      if ($urandom_range(0, 1) == 1)
         jx = -jx;
      jy = spread(30000);
      jz = spread(30000);
      if ($urandom_range(0, 9) == 0) begin
         jx = $urandom();
         jy = $urandom();
         jz = $urandom();
      end
      case (regime)
         0:       mag = $urandom_range(0, 20000);
         1:       mag = $urandom_range(20000, 140000);
         2:       mag = $urandom_range(150000, 700000);
         default: mag = $urandom_range(0, 8388607);
      endcase
      res = ($urandom_range(0, 1) == 1) ? -mag : mag;
      if (kind >= 98) begin
         res = ($urandom_range(0, 1) == 1) ? 8388607 : -8388608;
      end else if (kind >= 95) begin
         jx = 0;
         jy = 0;
         jz = 0;
      end else if (kind >= 92) begin
         // distance difference exactly as long as the separation
         by = ay;
         bz = az;
         dd = ($urandom_range(0, 1) == 1) ? s : -s;
      end else if (kind >= 88) begin
         bx = ax;
         by = ay;
         bz = az;
         dd = spread(1 << 20);
      end else if (kind >= 80) begin
         ax  = $urandom();
         ay  = $urandom();
         az  = $urandom();
         bx  = $urandom();
         by  = $urandom();
         bz  = $urandom();
         dd  = $urandom();
         res = $urandom();
         jx  = $urandom();
         jy  = $urandom();
         jz  = $urandom();
      end
      return pack_meas(ax, ay, az, bx, by, bz, dd, res, jx, jy, jz);
   endfunction

   function automatic gate_cfg_type random_cfg();
      gate_cfg_type c;
      int unsigned  base;
      base = $urandom_range(8000, 40000);
      for (int i = 0; i < GATE_LEVELS; i++) begin
         c.lvl[i] = tbog_pkg::LEVEL_W'(base * (i + 1) + $urandom_range(0, 8000));
         case ($urandom_range(0, 15))
            0:       c.lvl[i] = '0;
            1:       c.lvl[i] = '1;
            2:       c.lvl[i] = tbog_pkg::LEVEL_W'($urandom());
            default: ;
         endcase
      end
      if ($urandom_range(0, 3) == 0)
         c.accept_count = tbog_pkg::FILL_W'($urandom_range(0, 15));
      else
         c.accept_count = tbog_pkg::FILL_W'($urandom_range(1, 6));
      if ($urandom_range(0, 3) == 0)
         c.max_fill = tbog_pkg::FILL_W'($urandom_range(0, 15));
      else
         c.max_fill = tbog_pkg::FILL_W'($urandom_range(3, 12));
      if ($urandom_range(0, 3) == 0)
         c.close_delay = tbog_pkg::HOLD_W'($urandom_range(0, 255));
      else
         c.close_delay = tbog_pkg::HOLD_W'($urandom_range(0, 40));
      return c;
   endfunction

   task automatic write_one(input logic [tbog_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [tbog_pkg::CSR_DATA_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      verdicts.write_reg(idx, data);
      @(negedge clock);
   endtask

   // narrow registers get junk in the unused upper bits
   task automatic program_gate(input gate_cfg_type c);
      logic [tbog_pkg::CSR_DATA_W-1:0] data;
      for (int i = 0; i <= int'(tbog_pkg::CSR_LEVEL_LAST); i++)
         write_one(tbog_pkg::CSR_INDEX_W'(i), c.lvl[i]);
      data = tbog_pkg::CSR_DATA_W'($urandom());
      data[tbog_pkg::FILL_W-1:0] = c.accept_count;
      write_one(tbog_pkg::CSR_ACCEPT_COUNT, data);
      data = tbog_pkg::CSR_DATA_W'($urandom());
      data[tbog_pkg::FILL_W-1:0] = c.max_fill;
      write_one(tbog_pkg::CSR_MAX_FILL, data);
      data = tbog_pkg::CSR_DATA_W'($urandom());
      data[tbog_pkg::HOLD_W-1:0] = c.close_delay;
      write_one(tbog_pkg::CSR_CLOSE_DELAY, data);
      csr_wen <= 1'b0;
   endtask

   task automatic offer(input measurement_type m);
      req_if.valid         <= 1'b1;
      req_if.anchor_a_x    <= m.anchor_a_x;
      req_if.anchor_a_y    <= m.anchor_a_y;
      req_if.anchor_a_z    <= m.anchor_a_z;
      req_if.anchor_b_x    <= m.anchor_b_x;
      req_if.anchor_b_y    <= m.anchor_b_y;
      req_if.anchor_b_z    <= m.anchor_b_z;
      req_if.distance_diff <= m.distance_diff;
      req_if.residual      <= m.residual;
      req_if.jac_x         <= m.jac_x;
      req_if.jac_y         <= m.jac_y;
      req_if.jac_z         <= m.jac_z;
      do
         @(posedge clock);
      while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic pause_sender(input int unsigned n);
      if (n != 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      while (verdicts.pending() != 0)
         @(negedge clock);
   endtask

   task automatic settle();
      wait_drained();
      repeat (4) @(negedge clock);
   endtask

   task automatic run_directed();
      measurement_type list [$];
      list.push_back(pack_meas(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      list.push_back(pack_meas(1000, 2000, 3000, 1000, 2000, 3000, 0, 5, 65536, 0, 0));
      // difference equal to the separation, both signs
      list.push_back(pack_meas(100000, 0, 0, 0, 0, 0, 100000, 0, 65536, 0, 0));
      list.push_back(pack_meas(100000, 0, 0, 0, 0, 0, -100000, 0, 65536, 0, 0));
      list.push_back(pack_meas(100000, 0, 0, 0, 0, 0, 99999, 0, 65536, 0, 0));
      list.push_back(pack_meas(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                               -8388608, -8388608, -524288, -524288, -524288));
      list.push_back(pack_meas(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                               8388607, 8388607, 524287, 524287, 524287));
      // zero jacobian
      list.push_back(pack_meas(100000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      list.push_back(pack_meas(100000, 0, 0, 0, 0, 0, 0, 8388607, 0, 0, 0));
      list.push_back(pack_meas(100000, 0, 0, 0, 0, 0, 0, 8388607, 1, 0, 0));
      list.push_back(pack_meas(100000, 0, 0, 0, 0, 0, 0, 1, 524287, 524287, 524287));
      // error right on a level and just below it
      list.push_back(pack_meas(100000, 0, 0, 0, 0, 0, 0, 26214, 65536, 0, 0));
      list.push_back(pack_meas(100000, 0, 0, 0, 0, 0, 0, 26213, 65536, 0, 0));
      list.push_back(pack_meas(100000, 0, 0, 0, 0, 0, 0, -131072, 0, 0, -65536));
      repeat (5) list.push_back(pack_meas(100000, 0, 0, 0, 0, 0, 0, 600000, 65536, 0, 0));
      repeat (4) list.push_back(pack_meas(100000, 0, 0, 0, 0, 0, 0, 0, 0, 65536, 0));
      foreach (list[i]) begin
         offer(list[i]);
         pause_sender($urandom_range(0, 3));
      end
      req_if.valid <= 1'b0;
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned sent, burst, regime, regime_left, pick;
      sent        = 0;
      regime      = 0;
      regime_left = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         for (int k = 0; k < burst && sent < count; k++) begin
            if (regime_left == 0) begin
               pick        = $urandom_range(0, 9);
               regime      = (pick == 9) ? 3 : pick / 3;
               regime_left = $urandom_range(4, 40);
            end
            regime_left--;
            offer(make_measurement(regime));
            sent++;
         end
         case ($urandom_range(0, 5))
            0, 1:    pause_sender(0);
            2:       pause_sender($urandom_range(20, 60));
            default: pause_sender($urandom_range(1, 12));
         endcase
      end
      req_if.valid <= 1'b0;
   endtask

   // receiver pacing, with a long hold-off on request
   initial begin : rx_pacing
      int unsigned mode, left, holds_done;
      rsp_if.ready = 1'b0;
      mode         = 0;
      left         = 0;
      holds_done   = 0;
      forever begin
         @(negedge clock);
         if (holds_done != rx_hold_requests) begin
            holds_done++;
            rsp_if.ready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(negedge clock);
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 300);
         end
         left--;
         case (mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 9) < 7);
            2:       rsp_if.ready <= ($urandom_range(0, 9) < 2);
            default: rsp_if.ready <= (left % 6 == 0);
         endcase
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      gate_cfg_type c;
      reset                = 1'b1;
      csr_wen              = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.anchor_a_x    = '0;
      req_if.anchor_a_y    = '0;
      req_if.anchor_a_z    = '0;
      req_if.anchor_b_x    = '0;
      req_if.anchor_b_y    = '0;
      req_if.anchor_b_z    = '0;
      req_if.distance_diff = '0;
      req_if.residual      = '0;
      req_if.jac_x         = '0;
      req_if.jac_y         = '0;
      req_if.jac_z         = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      wait_drained();
      run_random(150);
      // sender waits for every verdict, then offers while the receiver holds off
      wait_drained();
      rx_hold_requests++;
      run_random(150);

      settle();
      c.lvl          = {24'd180000, 24'd120000, 24'd80000, 24'd45000, 24'd20000};
      c.accept_count = 4'd15;
      c.max_fill     = 4'd15;
      c.close_delay  = 8'd255;
      program_gate(c);
      run_random(150);

      // max fill dropped below buckets that are still high
      settle();
      c.accept_count = 4'd2;
      c.max_fill     = 4'd2;
      c.close_delay  = 8'd5;
      program_gate(c);
      run_random(120);

      settle();
      c.lvl          = {24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF};
      c.accept_count = 4'd0;
      c.max_fill     = 4'd1;
      c.close_delay  = 8'd0;
      program_gate(c);
      run_random(100);

      settle();
      c.lvl          = {24'd150000, 24'd100000, 24'd60000, 24'd0, 24'd0};
      c.accept_count = 4'd1;
      c.max_fill     = 4'd0;
      c.close_delay  = 8'd0;
      program_gate(c);
      run_random(100);

      repeat (4) begin
         settle();
         program_gate(random_cfg());
         run_random(100);
      end

      settle();
      program_gate(CFG_AT_RESET);
      run_random(100);

      wait_drained();
      repeat (60) @(negedge clock);
      if (verdicts.mismatches == 0 && verdicts.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
